// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define CIE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define CIE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cie_pkg.sv =====
// ----------------------------------------------------------------------------
// cie_pkg
// Constants, types and character classes for the identifier extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cie_pkg;

   localparam int ID_BUFFER_BYTES = 31;
   localparam int ID_CAPACITY     = ID_BUFFER_BYTES - 1;
   localparam int ID_ADDR_W       = (ID_CAPACITY > 1) ? $clog2(ID_CAPACITY) : 1;
   localparam int ID_LEN_W        = $clog2(ID_CAPACITY + 1);

   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   typedef logic [ID_ADDR_W-1:0] addr_type;
   typedef logic [ID_LEN_W-1:0]  len_type;

   typedef struct packed {
      logic       en;
      addr_type   addr;
      logic [7:0] data;
   } store_wr_type;

   typedef struct packed {
      logic     start;
      addr_type last_idx;
      logic     trunc;
   } flush_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
             || c == CH_UNDERSCORE;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/cie_drain.sv =====
// ----------------------------------------------------------------------------
// cie_drain
// Identifier store and the sequencer that reads a flushed identifier out,
// one character per word, into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cie_drain (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cie_pkg::store_wr_type wr,
   input  wire cie_pkg::flush_type    flush,
   output logic                       busy,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_id_char,
   output logic                       rsp_id_last,
   output logic                       rsp_id_truncated
);
   import cie_pkg::*;

   logic [7:0] store_mem [ID_CAPACITY];

   logic       active_ff;
   addr_type   cnt_ff;
   addr_type   last_idx_ff;
   logic       trunc_ff;
   logic       rsp_valid_ff;
   logic [7:0] rd_data_ff;
   logic       rsp_last_ff;
   logic       rsp_trunc_ff;
   logic       fire;

   assign fire = active_ff && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      if (fire) begin
         rd_data_ff   <= store_mem[cnt_ff];
         rsp_last_ff  <= (cnt_ff == last_idx_ff);
         rsp_trunc_ff <= trunc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         last_idx_ff  <= '0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (flush.start && !active_ff) begin
            active_ff   <= 1'b1;
            cnt_ff      <= '0;
            last_idx_ff <= flush.last_idx;
            trunc_ff    <= flush.trunc;
         end else if (fire) begin
            cnt_ff <= cnt_ff + addr_type'(1);
            if (cnt_ff == last_idx_ff) begin
               active_ff <= 1'b0;
            end
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign busy             = active_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_id_char      = rd_data_ff;
   assign rsp_id_last      = rsp_last_ff;
   assign rsp_id_truncated = rsp_trunc_ff;

endmodule

`default_nettype wire

// ===== hdl/c_identifier_extractor.sv =====
// Output: a separating byte flushes its identifier; the flush sets the drain active, and the
//   first character word is then registered out, followed by one word per cycle unless rsp_ready stalls.
// Throughput: one byte per cycle while scanning; input stalls while an identifier is
//   read out from the store, including while output back-pressure holds the read-out.
// Reset: modes, length, overflow and output valid clear; store holds stale data.
// ----------------------------------------------------------------------------
// c_identifier_extractor
// Scans source bytes, tracks comment and string modes and builds identifiers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c_identifier_extractor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic [7:0] req_next_ch,
   input  wire logic       req_line_start,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_id_char,
   output logic            rsp_id_last,
   output logic            rsp_id_truncated
);
   import cie_pkg::*;

   logic    line_ff, block_ff, string_ff, ovf_ff;
   len_type len_ff;
   logic    line_in, block_in, string_in, ovf_in;
   len_type len_in;
   logic    lc, any_mode, letter, digit, accept, busy;
   store_wr_type wr;
   flush_type    flush;

   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;
   assign letter    = is_letter(req_ch);
   assign digit     = is_digit(req_ch);

   always_comb begin
      lc        = req_line_start ? 1'b0 : line_ff;
      line_in   = lc;
      block_in  = block_ff;
      string_in = string_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      wr        = '0;
      flush     = '0;
      wr.addr   = len_ff[ID_ADDR_W-1:0];
      wr.data   = req_ch;
      flush.last_idx = addr_type'(len_ff - len_type'(1));
      flush.trunc    = ovf_ff;

      if (!lc && !block_ff && !string_ff) begin
         if (req_ch == CH_SLASH) begin
            if (req_next_ch == CH_SLASH) begin
               line_in = 1'b1;
            end else if (req_next_ch == CH_STAR) begin
               block_in = 1'b1;
            end
         end else if (req_ch == CH_QUOTE) begin
            string_in = 1'b1;
         end
      end else begin
         if (block_ff && req_ch == CH_STAR && req_next_ch == CH_SLASH) begin
            block_in = 1'b0;
         end else if (string_ff && req_ch == CH_QUOTE) begin
            string_in = 1'b0;
         end
      end
      any_mode = line_in || block_in || string_in;

      if (any_mode || (len_ff != '0 && !letter && !digit)) begin
         flush.start = (len_ff != '0);
         len_in      = '0;
         ovf_in      = 1'b0;
      end else if (len_ff == '0) begin
         if (letter) begin
            wr.en  = 1'b1;
            len_in = len_type'(1);
         end
      end else if (len_ff < len_type'(ID_CAPACITY)) begin
         wr.en  = 1'b1;
         len_in = len_ff + len_type'(1);
      end else begin
         ovf_in = 1'b1;
      end

      if (!accept) begin
         wr.en       = 1'b0;
         flush.start = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff   <= 1'b0;
         block_ff  <= 1'b0;
         string_ff <= 1'b0;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else if (accept) begin
         line_ff   <= line_in;
         block_ff  <= block_in;
         string_ff <= string_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
      end
   end

   cie_drain u_drain (
      .clock            (clock),
      .reset            (reset),
      .wr               (wr),
      .flush            (flush),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_id_char      (rsp_id_char),
      .rsp_id_last      (rsp_id_last),
      .rsp_id_truncated (rsp_id_truncated)
   );

endmodule

`default_nettype wire

// ===== hdl/cie_checker.sv =====
// ----------------------------------------------------------------------------
// cie_checker
// Port-level checks on the identifier extractor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cie_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_id_char,
   input wire logic       rsp_id_last,
   input wire logic       rsp_id_truncated
);

   `CIE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp word dropped while stalled")
   `CIE_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_id_char) && $stable(rsp_id_last) && $stable(rsp_id_truncated), "rsp payload changed while stalled")
   `CIE_ASSERT(a_input_held, clock, reset, rsp_valid && !rsp_id_last |-> !req_ready, "input taken mid identifier")
   `CIE_ASSERT(a_first_same, clock, reset, rsp_valid && rsp_ready && !rsp_id_last |=> rsp_id_truncated == $past(rsp_id_truncated), "truncation flag changed within identifier")
   `CIE_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind c_identifier_extractor cie_checker u_cie_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_id_char      (rsp_id_char),
   .rsp_id_last      (rsp_id_last),
   .rsp_id_truncated (rsp_id_truncated)
);

`default_nettype wire
